// ----- rtl/mfal_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfal_pkg: shared types and constants for the mail From: address locator
// Byte codes, field widths and the final-state flag group handed from the
// scanner to the result stage.
// ----------------------------------------------------------------------------
package mfal_pkg;

    localparam int DEF_MAX_LINE = 1024;

    localparam int BYTE_W   = 8;
    localparam int START_W  = 10;
    localparam int LEN_W    = 11;
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 24;
    localparam int M_USER_W = 1;

    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [BYTE_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [BYTE_W-1:0] CH_LANGLE = 8'h3C;
    localparam logic [BYTE_W-1:0] CH_RANGLE = 8'h3E;
    localparam logic [BYTE_W-1:0] CH_SEMI   = 8'h3B;
    localparam logic [BYTE_W-1:0] CH_AT     = 8'h40;
    localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;

    localparam logic signed [7:0] DEPTH_MAX = 8'sd127;
    localparam logic signed [7:0] DEPTH_MIN = -8'sd128;

    // which positions of a finished line hold a valid value, plus the overflow flag
    typedef struct packed {
        logic open_seen;
        logic close_seen;
        logic at_seen;
        logic blank_after_at_seen;
        logic stop_seen;
        logic overflow;
    } mfal_flags_t;

endpackage

// ----- rtl/mfal_scan.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfal_scan: per-byte scanner
// Tracks escapes, quotes and comment depth, records top-level delimiter
// positions and hands the final line state out on the last byte.
// ----------------------------------------------------------------------------
module mfal_scan #(
    parameter int MAX_LINE = mfal_pkg::DEF_MAX_LINE,
    parameter int CNT_W    = $clog2(MAX_LINE + 1)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        step_en,
    input  logic [mfal_pkg::BYTE_W-1:0] step_byte,
    input  logic                        step_last,
    output mfal_pkg::mfal_flags_t       fin_flags,
    output logic [CNT_W-1:0]            fin_open_pos,
    output logic [CNT_W-1:0]            fin_close_pos,
    output logic [CNT_W-1:0]            fin_start_after_blank,
    output logic [CNT_W-1:0]            fin_blank_after_at_pos,
    output logic [CNT_W-1:0]            fin_stop_pos,
    output logic [CNT_W-1:0]            fin_end_pos
);
    import mfal_pkg::*;

    // control state
    logic [CNT_W-1:0]   byte_pos_reg, byte_pos_next;
    logic               escape_reg, escape_next;
    logic               quotes_reg, quotes_next;
    logic signed [7:0]  depth_reg, depth_next;
    logic               stopped_reg, stopped_next;
    mfal_flags_t        flags_reg, flags_next;
    logic               blank_seen_reg, blank_seen_next;

    // positions, qualified by the flags
    logic [CNT_W-1:0]   open_pos_reg, open_pos_next;
    logic [CNT_W-1:0]   close_pos_reg, close_pos_next;
    logic [CNT_W-1:0]   sab_reg, sab_next;
    logic [CNT_W-1:0]   last_blank_reg, last_blank_next;
    logic [CNT_W-1:0]   bla_pos_reg, bla_pos_next;
    logic [CNT_W-1:0]   stop_pos_reg, stop_pos_next;

    logic               is_blank;

    assign is_blank = (step_byte == CH_SPACE) || (step_byte == CH_TAB);

    always_comb begin
        byte_pos_next   = byte_pos_reg;
        escape_next     = escape_reg;
        quotes_next     = quotes_reg;
        depth_next      = depth_reg;
        stopped_next    = stopped_reg;
        flags_next      = flags_reg;
        blank_seen_next = blank_seen_reg;
        open_pos_next   = open_pos_reg;
        close_pos_next  = close_pos_reg;
        sab_next        = sab_reg;
        last_blank_next = last_blank_reg;
        bla_pos_next    = bla_pos_reg;
        stop_pos_next   = stop_pos_reg;

        if (byte_pos_reg == CNT_W'(MAX_LINE)) begin
            // line too long: byte dropped
            flags_next.overflow = 1'b1;
        end else begin
            byte_pos_next = byte_pos_reg + 1'b1;
            if (!stopped_reg) begin
                // blanks count on raw bytes, quoted or not
                if (is_blank) begin
                    last_blank_next = byte_pos_reg;
                    blank_seen_next = 1'b1;
                    if (flags_reg.at_seen && !flags_reg.blank_after_at_seen) begin
                        bla_pos_next                   = byte_pos_reg;
                        flags_next.blank_after_at_seen = 1'b1;
                    end
                end

                if (escape_reg) begin
                    escape_next = 1'b0;
                end else if (step_byte == CH_BSLASH) begin
                    escape_next = 1'b1;
                end else if (step_byte == CH_DQUOTE) begin
                    quotes_next = !quotes_reg;
                end else if (quotes_reg) begin
                    escape_next = 1'b0;
                end else if (step_byte == CH_LPAREN) begin
                    if (depth_reg < DEPTH_MAX) begin
                        depth_next = depth_reg + 8'sd1;
                    end
                end else if (step_byte == CH_RPAREN) begin
                    if (depth_reg > DEPTH_MIN) begin
                        depth_next = depth_reg - 8'sd1;
                    end
                end else if (depth_reg == 8'sd0) begin
                    case (step_byte)
                        CH_LANGLE: begin
                            open_pos_next        = byte_pos_reg;
                            flags_next.open_seen = 1'b1;
                        end
                        CH_RANGLE: begin
                            close_pos_next        = byte_pos_reg;
                            flags_next.close_seen = 1'b1;
                            if (flags_reg.open_seen) begin
                                stopped_next = 1'b1;
                            end
                        end
                        CH_SEMI: begin
                            stop_pos_next        = byte_pos_reg;
                            flags_next.stop_seen = 1'b1;
                            stopped_next         = 1'b1;
                        end
                        CH_AT: begin
                            flags_next.at_seen             = 1'b1;
                            flags_next.blank_after_at_seen = 1'b0;
                            sab_next = blank_seen_reg ? last_blank_reg + 1'b1 : '0;
                        end
                        default: begin
                            stopped_next = stopped_reg;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step_en && step_last)) begin
            byte_pos_reg   <= '0;
            escape_reg     <= 1'b0;
            quotes_reg     <= 1'b0;
            depth_reg      <= 8'sd0;
            stopped_reg    <= 1'b0;
            flags_reg      <= '0;
            blank_seen_reg <= 1'b0;
        end else if (step_en) begin
            byte_pos_reg   <= byte_pos_next;
            escape_reg     <= escape_next;
            quotes_reg     <= quotes_next;
            depth_reg      <= depth_next;
            stopped_reg    <= stopped_next;
            flags_reg      <= flags_next;
            blank_seen_reg <= blank_seen_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            open_pos_reg   <= open_pos_next;
            close_pos_reg  <= close_pos_next;
            sab_reg        <= sab_next;
            last_blank_reg <= last_blank_next;
            bla_pos_reg    <= bla_pos_next;
            stop_pos_reg   <= stop_pos_next;
        end
    end

    assign fin_flags              = flags_next;
    assign fin_open_pos           = open_pos_next;
    assign fin_close_pos          = close_pos_next;
    assign fin_start_after_blank  = sab_next;
    assign fin_blank_after_at_pos = bla_pos_next;
    assign fin_stop_pos           = stop_pos_next;
    assign fin_end_pos            = byte_pos_next;

endmodule

// ----- rtl/mfal_result.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfal_result: address selection
// Holds the final state of a line and derives start and length of the
// address from the angle, at-sign and stop positions.
// ----------------------------------------------------------------------------
module mfal_result #(
    parameter int MAX_LINE = mfal_pkg::DEF_MAX_LINE,
    parameter int CNT_W    = $clog2(MAX_LINE + 1)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         shift,
    input  logic                         take,
    input  mfal_pkg::mfal_flags_t        fin_flags,
    input  logic [CNT_W-1:0]             fin_open_pos,
    input  logic [CNT_W-1:0]             fin_close_pos,
    input  logic [CNT_W-1:0]             fin_start_after_blank,
    input  logic [CNT_W-1:0]             fin_blank_after_at_pos,
    input  logic [CNT_W-1:0]             fin_stop_pos,
    input  logic [CNT_W-1:0]             fin_end_pos,
    output logic                         res_valid,
    output logic [mfal_pkg::START_W-1:0] res_start,
    output logic [mfal_pkg::LEN_W-1:0]   res_length,
    output logic                         res_overflow
);
    import mfal_pkg::*;

    logic               snap_valid_reg;
    mfal_flags_t        snap_flags_reg;
    logic [CNT_W-1:0]   snap_open_reg;
    logic [CNT_W-1:0]   snap_close_reg;
    logic [CNT_W-1:0]   snap_sab_reg;
    logic [CNT_W-1:0]   snap_bla_reg;
    logic [CNT_W-1:0]   snap_stop_reg;
    logic [CNT_W-1:0]   snap_end_reg;

    logic [CNT_W-1:0]   at_end;
    logic [CNT_W-1:0]   start_c;
    logic [CNT_W-1:0]   length_c;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snap_valid_reg <= 1'b0;
        end else if (shift) begin
            snap_valid_reg <= take;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift && take) begin
            snap_flags_reg <= fin_flags;
            snap_open_reg  <= fin_open_pos;
            snap_close_reg <= fin_close_pos;
            snap_sab_reg   <= fin_start_after_blank;
            snap_bla_reg   <= fin_blank_after_at_pos;
            snap_stop_reg  <= fin_stop_pos;
            snap_end_reg   <= fin_end_pos;
        end
    end

    always_comb begin
        if (snap_flags_reg.blank_after_at_seen) begin
            at_end = snap_bla_reg;
        end else if (snap_flags_reg.stop_seen) begin
            at_end = snap_stop_reg;
        end else begin
            at_end = snap_end_reg;
        end

        start_c  = '0;
        length_c = '0;
        if (snap_flags_reg.open_seen && snap_flags_reg.close_seen) begin
            // '>' ahead of the last '<' leaves the result empty
            if (snap_close_reg > snap_open_reg) begin
                start_c  = snap_open_reg + 1'b1;
                length_c = snap_close_reg - snap_open_reg - 1'b1;
            end
        end else if (snap_flags_reg.at_seen) begin
            start_c = snap_sab_reg;
            if (at_end > snap_sab_reg) begin
                length_c = at_end - snap_sab_reg;
            end
        end
        if (length_c == '0) begin
            start_c = '0;
        end
    end

    assign res_valid    = snap_valid_reg;
    assign res_start    = START_W'(start_c);
    assign res_length   = LEN_W'(length_c);
    assign res_overflow = snap_flags_reg.overflow;

endmodule

// ----- rtl/mail_from_address_locator_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mail_from_address_locator_top: From: header address locator
// Scans header bytes and reports start and length of the mail address
// once per line.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                    | tlast     | tuser
//  s_      | in  | header_byte[7:0]                      | last_byte | -
//  m_      | out | address_start[9:0], address_length    | -         | line_overflow
//
//  One byte per cycle while s_tready is high; the per-byte state update is the loop.
//  After its last byte is accepted, a result passes the input register, the
//  line snapshot and the output register.
//  Synchronous active-low reset clears the line state and all valid flags.
//  s_tready drops only while a finished line waits behind a full output.
// ----------------------------------------------------------------------------
module mail_from_address_locator_top #(
    parameter int MAX_LINE = mfal_pkg::DEF_MAX_LINE
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [mfal_pkg::S_DATA_W-1:0] s_tdata,   // header_byte[7:0]
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // address_start[9:0], address_length[20:10], zero pad [23:21]
    output logic [mfal_pkg::M_DATA_W-1:0] m_tdata,
    output logic [mfal_pkg::M_USER_W-1:0] m_tuser    // line_overflow[0]
);
    import mfal_pkg::*;

    localparam int CNT_W = $clog2(MAX_LINE + 1);

    logic                 advance;
    logic                 in_valid_reg;
    logic [BYTE_W-1:0]    in_byte_reg;
    logic                 in_last_reg;
    logic                 step_en;

    mfal_flags_t          fin_flags;
    logic [CNT_W-1:0]     fin_open_pos;
    logic [CNT_W-1:0]     fin_close_pos;
    logic [CNT_W-1:0]     fin_sab;
    logic [CNT_W-1:0]     fin_bla_pos;
    logic [CNT_W-1:0]     fin_stop_pos;
    logic [CNT_W-1:0]     fin_end_pos;

    logic                 res_valid;
    logic [START_W-1:0]   res_start;
    logic [LEN_W-1:0]     res_length;
    logic                 res_overflow;

    logic                 m_valid_reg;
    logic [M_DATA_W-1:0]  m_data_reg;
    logic [M_USER_W-1:0]  m_user_reg;

    // pipeline holds only when a finished line cannot move to the output
    assign advance  = !res_valid || !m_valid_reg || m_tready;
    assign s_tready = advance;
    assign step_en  = advance && in_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (advance) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            in_byte_reg <= s_tdata[BYTE_W-1:0];
            in_last_reg <= s_tlast;
        end
    end

    mfal_scan #(
        .MAX_LINE (MAX_LINE),
        .CNT_W    (CNT_W)
    ) u_scan (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .step_en                (step_en),
        .step_byte              (in_byte_reg),
        .step_last              (in_last_reg),
        .fin_flags              (fin_flags),
        .fin_open_pos           (fin_open_pos),
        .fin_close_pos          (fin_close_pos),
        .fin_start_after_blank  (fin_sab),
        .fin_blank_after_at_pos (fin_bla_pos),
        .fin_stop_pos           (fin_stop_pos),
        .fin_end_pos            (fin_end_pos)
    );

    mfal_result #(
        .MAX_LINE (MAX_LINE),
        .CNT_W    (CNT_W)
    ) u_result (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .shift                  (advance),
        .take                   (in_valid_reg && in_last_reg),
        .fin_flags              (fin_flags),
        .fin_open_pos           (fin_open_pos),
        .fin_close_pos          (fin_close_pos),
        .fin_start_after_blank  (fin_sab),
        .fin_blank_after_at_pos (fin_bla_pos),
        .fin_stop_pos           (fin_stop_pos),
        .fin_end_pos            (fin_end_pos),
        .res_valid              (res_valid),
        .res_start              (res_start),
        .res_length             (res_length),
        .res_overflow           (res_overflow)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            m_data_reg <= {(M_DATA_W - START_W - LEN_W)'(0), res_length, res_start};
            m_user_reg <= M_USER_W'(res_overflow);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

`ifndef SYNTHESIS
    // an empty address always reports start zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[START_W+LEN_W-1:START_W] == '0)) |->
            (m_tdata[START_W-1:0] == '0))
        else $error("empty address with nonzero start");

    // a finished line stuck behind a full output must block input
    assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && m_valid_reg && !m_tready) |-> !s_tready)
        else $error("input accepted while result stage is blocked");

    // an accepted last byte reaches the scanner next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> (in_valid_reg && in_last_reg))
        else $error("last byte lost at input register");

    // a line end reaching the scanner yields a pending result next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && in_last_reg) |=> res_valid)
        else $error("line end did not produce a result");
`endif

endmodule
